### rtl/trc_pkg.sv
// shared constants for the textured rectangle clipper
`timescale 1ns / 1ps
package trc_pkg;
   localparam int NUM_EDGES = 4;
   localparam logic [1:0] REG_CLIP_LEFT   = 2'd0;
   localparam logic [1:0] REG_CLIP_TOP    = 2'd1;
   localparam logic [1:0] REG_CLIP_RIGHT  = 2'd2;
   localparam logic [1:0] REG_CLIP_BOTTOM = 2'd3;
   localparam int CSR_INDEX_BITS = 3;
endpackage

### rtl/trc_div_cell.sv
// one restoring divide step of the quotient chain, registered
`timescale 1ns / 1ps
module trc_div_cell #(
   parameter int DW = 64,
   parameter int CW = 32,
   parameter int QW = 44
) (
   input  logic          clock,
   input  logic          en,
   input  logic [DW-1:0] num_in,
   input  logic [CW-1:0] den_in,
   input  logic [DW-1:0] rem_in,
   input  logic [QW-1:0] q_in,
   input  logic [QW-1:0] qcap,
   output logic [DW-1:0] num_out,
   output logic [CW-1:0] den_out,
   output logic [DW-1:0] rem_out,
   output logic [QW-1:0] q_out
);
   logic [DW-1:0] num_ff, rem_ff, rem_shift, rem_in_v;
   logic [CW-1:0] den_ff;
   logic [QW-1:0] q_ff, q_shift, q_in_v;
   logic          fits;

   // shift in the next dividend bit and try one subtract
   always_comb begin
      rem_shift = {rem_in[DW-2:0], num_in[DW-1]};
      fits      = rem_shift >= DW'(den_in);
      rem_in_v  = fits ? rem_shift - DW'(den_in) : rem_shift;
      q_shift   = (q_in >= qcap) ? qcap : {q_in[QW-2:0], 1'b0};
      q_in_v    = (fits && q_shift < qcap) ? (q_shift | QW'(1)) : q_shift;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         num_ff <= {num_in[DW-2:0], 1'b0};
         den_ff <= den_in;
         rem_ff <= rem_in_v;
         q_ff   <= q_in_v;
      end
   end
   assign num_out = num_ff;
   assign den_out = den_ff;
   assign rem_out = rem_ff;
   assign q_out   = q_ff;
endmodule

### rtl/trc_edge_lane.sv
// one edge lane: multiply, divider chain of cells, saturating add
`timescale 1ns / 1ps
module trc_edge_lane #(
   parameter int POS_BITS = 16,
   parameter int TEX_BITS = 16
) (
   input  logic                       clock,
   input  logic                       en,
   input  logic signed [POS_BITS:0]   d_in,
   input  logic signed [TEX_BITS:0]   et_in,
   input  logic signed [POS_BITS:0]   ep_in,
   input  logic signed [TEX_BITS-1:0] base_in,
   input  logic                       clip_in,
   output logic signed [TEX_BITS-1:0] tex_out
);
   localparam int PW = POS_BITS + TEX_BITS + 1;
   localparam int NS = PW;
   localparam int CW = POS_BITS + 1;
   localparam int QW = PW + 2;
   localparam int SW = QW + 1;

   // stage 0: magnitudes and product
   logic [POS_BITS:0] a_mag, c_mag;
   logic [TEX_BITS:0] b_mag;
   logic              neg;
   logic [PW-1:0]     prod_ff;
   logic [CW-1:0]     den_ff;
   logic              neg_ff, clip_ff;
   logic signed [TEX_BITS-1:0] base_ff;

   always_comb begin
      a_mag = d_in[POS_BITS] ? (POS_BITS+1)'(0) - d_in : d_in;
      b_mag = et_in[TEX_BITS] ? (TEX_BITS+1)'(0) - et_in : et_in;
      c_mag = ep_in[POS_BITS] ? (POS_BITS+1)'(0) - ep_in : ep_in;
      neg   = (d_in[POS_BITS] ^ et_in[TEX_BITS]) ^ ep_in[POS_BITS];
   end

   always_ff @(posedge clock) begin
      if (en) begin
         prod_ff <= PW'(a_mag * b_mag);
         den_ff  <= c_mag;
         neg_ff  <= neg;
         clip_ff <= clip_in;
         base_ff <= base_in;
      end
   end

   // divider chain of cells, one quotient bit per cell
   logic [PW-1:0] num_w [NS+1];
   logic [CW-1:0] den_w [NS+1];
   logic [PW-1:0] rem_w [NS+1];
   logic [QW-1:0] q_w   [NS+1];
   logic [NS-1:0] neg_sr [1];
   logic [NS-1:0] clip_sr;
   logic signed [TEX_BITS-1:0] base_sr [NS];
   localparam logic [QW-1:0] QCAP = QW'(1) << (QW - 1);

   assign num_w[0] = prod_ff;
   assign den_w[0] = den_ff;
   assign rem_w[0] = '0;
   assign q_w[0]   = '0;

   for (genvar i = 0; i < NS; i++) begin : g_cell
      trc_div_cell #(.DW(PW), .CW(CW), .QW(QW)) u_cell (
         .clock(clock), .en(en),
         .num_in(num_w[i]), .den_in(den_w[i]), .rem_in(rem_w[i]), .q_in(q_w[i]),
         .qcap(QCAP),
         .num_out(num_w[i+1]), .den_out(den_w[i+1]), .rem_out(rem_w[i+1]),
         .q_out(q_w[i+1])
      );
   end

   // side data riding along the chain
   always_ff @(posedge clock) begin
      if (en) begin
         neg_sr[0]  <= {neg_sr[0][NS-2:0], neg_ff};
         clip_sr    <= {clip_sr[NS-2:0], clip_ff};
         base_sr[0] <= base_ff;
         for (int k = 1; k < NS; k++) base_sr[k] <= base_sr[k-1];
      end
   end

   // final stage: signed quotient plus base, saturated, or the base alone when the edge is not clipped
   logic signed [SW-1:0] sq, sum;
   logic signed [TEX_BITS-1:0] sat_v, tex_ff;
   localparam logic signed [SW-1:0] HI = SW'((64'sd1 <<< (TEX_BITS - 1)) - 1);
   localparam logic signed [SW-1:0] LO = -HI - SW'(1);
   always_comb begin
      sq  = neg_sr[0][NS-1] ? -$signed({1'b0, q_w[NS]}) : $signed({1'b0, q_w[NS]});
      sum = sq + SW'(base_sr[NS-1]);
      if (sum > HI)      sat_v = TEX_BITS'(HI);
      else if (sum < LO) sat_v = TEX_BITS'(LO);
      else               sat_v = sum[TEX_BITS-1:0];
   end
   always_ff @(posedge clock) begin
      if (en) tex_ff <= clip_sr[NS-1] ? sat_v : base_sr[NS-1];
   end
   assign tex_out = tex_ff;
endmodule

### rtl/textured_rect_clipper_top.sv
// top level of the textured rectangle clipper
// each lane registers its operands, runs the divider chain of cells, then registers the result
// throughput: one item per cycle while the result side is not stalled, set by the divider chain of one step cells
// the whole pipeline holds while the result register is full and not taken
// reset: synchronous, clears valid bits and loads the full clip rectangle
`timescale 1ns / 1ps
module textured_rect_clipper_top #(
   parameter int POS_BITS = 16,
   parameter int TEX_BITS = 16
) (
   input  logic clock,
   input  logic reset,
   input  logic req_valid,
   output logic req_ready,
   input  logic signed [POS_BITS-1:0] req_pos_left,
   input  logic signed [POS_BITS-1:0] req_pos_top,
   input  logic signed [POS_BITS-1:0] req_pos_right,
   input  logic signed [POS_BITS-1:0] req_pos_bottom,
   input  logic signed [TEX_BITS-1:0] req_tex_left,
   input  logic signed [TEX_BITS-1:0] req_tex_top,
   input  logic signed [TEX_BITS-1:0] req_tex_right,
   input  logic signed [TEX_BITS-1:0] req_tex_bottom,
   output logic rsp_valid,
   input  logic rsp_ready,
   output logic rsp_rejected,
   output logic signed [POS_BITS-1:0] rsp_out_pos_left,
   output logic signed [POS_BITS-1:0] rsp_out_pos_top,
   output logic signed [POS_BITS-1:0] rsp_out_pos_right,
   output logic signed [POS_BITS-1:0] rsp_out_pos_bottom,
   output logic signed [TEX_BITS-1:0] rsp_out_tex_left,
   output logic signed [TEX_BITS-1:0] rsp_out_tex_top,
   output logic signed [TEX_BITS-1:0] rsp_out_tex_right,
   output logic signed [TEX_BITS-1:0] rsp_out_tex_bottom,
   input  logic csr_write,
   input  logic [trc_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [POS_BITS-1:0] csr_data
);
   import trc_pkg::*;
   localparam int DEPTH = POS_BITS + TEX_BITS + 3;

   logic signed [POS_BITS-1:0] clip_ff [NUM_EDGES];
   logic en;
   assign en = !rsp_valid || rsp_ready;
   assign req_ready = en;

   // clip registers
   always_ff @(posedge clock) begin
      if (reset) begin
         clip_ff[REG_CLIP_LEFT]   <= {1'b1, {(POS_BITS-1){1'b0}}};
         clip_ff[REG_CLIP_TOP]    <= {1'b1, {(POS_BITS-1){1'b0}}};
         clip_ff[REG_CLIP_RIGHT]  <= {1'b0, {(POS_BITS-1){1'b1}}};
         clip_ff[REG_CLIP_BOTTOM] <= {1'b0, {(POS_BITS-1){1'b1}}};
      end else if (csr_write && csr_index < CSR_INDEX_BITS'(NUM_EDGES)) begin
         clip_ff[csr_index[1:0]] <= csr_data;
      end
   end

   // per-edge clip decisions and lane operands
   logic signed [POS_BITS:0] ew, eh, d_l, d_t, d_r, d_b;
   logic signed [TEX_BITS:0] uw, vh;
   logic reject, cl_l, cl_t, cl_r, cl_b;
   always_comb begin
      ew = (POS_BITS+1)'(req_pos_right) - (POS_BITS+1)'(req_pos_left);
      eh = (POS_BITS+1)'(req_pos_bottom) - (POS_BITS+1)'(req_pos_top);
      uw = (TEX_BITS+1)'(req_tex_right) - (TEX_BITS+1)'(req_tex_left);
      vh = (TEX_BITS+1)'(req_tex_bottom) - (TEX_BITS+1)'(req_tex_top);
      d_l = (POS_BITS+1)'(clip_ff[REG_CLIP_LEFT]) - (POS_BITS+1)'(req_pos_left);
      d_t = (POS_BITS+1)'(clip_ff[REG_CLIP_TOP]) - (POS_BITS+1)'(req_pos_top);
      d_r = (POS_BITS+1)'(clip_ff[REG_CLIP_RIGHT]) - (POS_BITS+1)'(req_pos_right);
      d_b = (POS_BITS+1)'(clip_ff[REG_CLIP_BOTTOM]) - (POS_BITS+1)'(req_pos_bottom);
      reject = req_pos_right < clip_ff[REG_CLIP_LEFT] || req_pos_left > clip_ff[REG_CLIP_RIGHT]
            || req_pos_bottom < clip_ff[REG_CLIP_TOP] || req_pos_top > clip_ff[REG_CLIP_BOTTOM];
      cl_l = clip_ff[REG_CLIP_LEFT] > req_pos_left && ew != 0;
      cl_t = clip_ff[REG_CLIP_TOP] > req_pos_top && eh != 0;
      cl_r = clip_ff[REG_CLIP_RIGHT] < req_pos_right && ew != 0;
      cl_b = clip_ff[REG_CLIP_BOTTOM] < req_pos_bottom && eh != 0;
   end

   // four texcoord lanes
   logic signed [TEX_BITS-1:0] tx_l, tx_t, tx_r, tx_b;
   trc_edge_lane #(.POS_BITS(POS_BITS), .TEX_BITS(TEX_BITS)) u_lane_l (
      .clock(clock), .en(en), .d_in(d_l), .et_in(uw), .ep_in(ew),
      .base_in(req_tex_left), .clip_in(cl_l), .tex_out(tx_l));
   trc_edge_lane #(.POS_BITS(POS_BITS), .TEX_BITS(TEX_BITS)) u_lane_t (
      .clock(clock), .en(en), .d_in(d_t), .et_in(vh), .ep_in(eh),
      .base_in(req_tex_top), .clip_in(cl_t), .tex_out(tx_t));
   trc_edge_lane #(.POS_BITS(POS_BITS), .TEX_BITS(TEX_BITS)) u_lane_r (
      .clock(clock), .en(en), .d_in(d_r), .et_in(uw), .ep_in(ew),
      .base_in(req_tex_right), .clip_in(cl_r), .tex_out(tx_r));
   trc_edge_lane #(.POS_BITS(POS_BITS), .TEX_BITS(TEX_BITS)) u_lane_b (
      .clock(clock), .en(en), .d_in(d_b), .et_in(vh), .ep_in(eh),
      .base_in(req_tex_bottom), .clip_in(cl_b), .tex_out(tx_b));

   // position and control delay line matching the lanes
   logic [DEPTH-1:0] vld_ff, rej_ff;
   logic signed [POS_BITS-1:0] p_ff [DEPTH][NUM_EDGES];
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= {vld_ff[DEPTH-2:0], req_valid};
      end
   end
   always_ff @(posedge clock) begin
      if (en) begin
         rej_ff  <= {rej_ff[DEPTH-2:0], reject};
         p_ff[0][REG_CLIP_LEFT]   <= cl_l ? clip_ff[REG_CLIP_LEFT] : req_pos_left;
         p_ff[0][REG_CLIP_TOP]    <= cl_t ? clip_ff[REG_CLIP_TOP] : req_pos_top;
         p_ff[0][REG_CLIP_RIGHT]  <= cl_r ? clip_ff[REG_CLIP_RIGHT] : req_pos_right;
         p_ff[0][REG_CLIP_BOTTOM] <= cl_b ? clip_ff[REG_CLIP_BOTTOM] : req_pos_bottom;
         for (int k = 1; k < DEPTH; k++) p_ff[k] <= p_ff[k-1];
      end
   end

   // result outputs, zeroed when rejected
   logic rj;
   assign rj = rej_ff[DEPTH-1];
   assign rsp_valid          = vld_ff[DEPTH-1];
   assign rsp_rejected       = rj;
   assign rsp_out_pos_left   = rj ? '0 : p_ff[DEPTH-1][REG_CLIP_LEFT];
   assign rsp_out_pos_top    = rj ? '0 : p_ff[DEPTH-1][REG_CLIP_TOP];
   assign rsp_out_pos_right  = rj ? '0 : p_ff[DEPTH-1][REG_CLIP_RIGHT];
   assign rsp_out_pos_bottom = rj ? '0 : p_ff[DEPTH-1][REG_CLIP_BOTTOM];
   assign rsp_out_tex_left   = rj ? '0 : tx_l;
   assign rsp_out_tex_top    = rj ? '0 : tx_t;
   assign rsp_out_tex_right  = rj ? '0 : tx_r;
   assign rsp_out_tex_bottom = rj ? '0 : tx_b;

   // a stalled result stays valid and holds its left position and left texcoord
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_out_pos_left) && $stable(rsp_out_tex_left))
      else $error("stalled result changed");
   // input is taken exactly when the pipeline moves
   a_ready: assert property (@(posedge clock) disable iff (reset)
      req_ready == (!rsp_valid || rsp_ready))
      else $error("ready out of step with pipeline");
   // a rejected result carries zero left and right positions
   a_rej: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_rejected |-> rsp_out_pos_left == 0 && rsp_out_pos_right == 0)
      else $error("rejected result not cleared");
endmodule

### bench/testbench.sv
// testbench for the textured rectangle clipper: directed table, random items, field checks
`timescale 1ns / 1ps
module testbench;
   import trc_pkg::*;

   localparam int PB = 16;
   localparam int TB = 16;
   localparam int DRAIN_CYCLES = PB + TB + 24;

   typedef struct packed {
      logic signed [PB-1:0] pl, pt, pr, pb;
      logic signed [TB-1:0] tl, tt, tr, tb;
   } rect_type;

   typedef struct packed {
      logic                 rej;
      logic signed [PB-1:0] pl, pt, pr, pb;
      logic signed [TB-1:0] tl, tt, tr, tb;
   } clip_res_type;

   typedef struct {
      rect_type     item;
      bit           typed;
      clip_res_type res;
   } table_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   rect_type req_item = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   clip_res_type rsp_item;
   logic csr_write = 1'b0;
   logic [CSR_INDEX_BITS-1:0] csr_index = '0;
   logic [PB-1:0] csr_data = '0;

   // expected clipped rectangles, oldest first
   clip_res_type clipped_q[$];
   logic signed [PB-1:0] clip_edge[4];
   int errors = 0;
   int results_seen = 0;
   int items_sent = 0;
   int rejects_seen = 0;
   bit no_idle = 1'b0;
   bit hold_request = 1'b0;
   int hold_left = 0;

   always #6 clock = ~clock;

   textured_rect_clipper_top dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready),
      .req_pos_left(req_item.pl), .req_pos_top(req_item.pt),
      .req_pos_right(req_item.pr), .req_pos_bottom(req_item.pb),
      .req_tex_left(req_item.tl), .req_tex_top(req_item.tt),
      .req_tex_right(req_item.tr), .req_tex_bottom(req_item.tb),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .rsp_rejected(rsp_item.rej),
      .rsp_out_pos_left(rsp_item.pl), .rsp_out_pos_top(rsp_item.pt),
      .rsp_out_pos_right(rsp_item.pr), .rsp_out_pos_bottom(rsp_item.pb),
      .rsp_out_tex_left(rsp_item.tl), .rsp_out_tex_top(rsp_item.tt),
      .rsp_out_tex_right(rsp_item.tr), .rsp_out_tex_bottom(rsp_item.tb),
      .csr_write(csr_write), .csr_index(csr_index), .csr_data(csr_data)
   );

   // base + trunc(d * et / ep), saturated to the texcoord range
   function automatic logic signed [TB-1:0] lerp_tex(longint base, longint d, longint et,
                                                    longint ep);
      longint q;
      longint s;
      q = ((d < 0 ? -d : d) * (et < 0 ? -et : et)) / (ep < 0 ? -ep : ep);
      if (((d < 0) != (et < 0)) != (ep < 0)) q = -q;
      s = base + q;
      if (s > 32767) s = 32767;
      if (s < -32768) s = -32768;
      return s[TB-1:0];
   endfunction

   function automatic clip_res_type clip_rect(rect_type r);
      clip_res_type o;
      longint cl, ct, cr, cb, ew, eh;
      cl = clip_edge[REG_CLIP_LEFT];
      ct = clip_edge[REG_CLIP_TOP];
      cr = clip_edge[REG_CLIP_RIGHT];
      cb = clip_edge[REG_CLIP_BOTTOM];
      o = '0;
      if (r.pr < cl || r.pl > cr || r.pb < ct || r.pt > cb) begin
         o.rej = 1'b1;
         return o;
      end
      ew = longint'(r.pr) - r.pl;
      eh = longint'(r.pb) - r.pt;
      o.pl = r.pl; o.pt = r.pt; o.pr = r.pr; o.pb = r.pb;
      o.tl = r.tl; o.tt = r.tt; o.tr = r.tr; o.tb = r.tb;
      if (cl > r.pl && ew != 0) begin
         o.pl = cl[PB-1:0];
         o.tl = lerp_tex(r.tl, cl - r.pl, longint'(r.tr) - r.tl, ew);
      end
      if (ct > r.pt && eh != 0) begin
         o.pt = ct[PB-1:0];
         o.tt = lerp_tex(r.tt, ct - r.pt, longint'(r.tb) - r.tt, eh);
      end
      if (cr < r.pr && ew != 0) begin
         o.pr = cr[PB-1:0];
         o.tr = lerp_tex(r.tr, cr - r.pr, longint'(r.tr) - r.tl, ew);
      end
      if (cb < r.pb && eh != 0) begin
         o.pb = cb[PB-1:0];
         o.tb = lerp_tex(r.tb, cb - r.pb, longint'(r.tb) - r.tt, eh);
      end
      return o;
   endfunction

   task automatic check_field(string name, longint exp_v, longint act_v);
      if (exp_v != act_v) begin
         errors++;
         $display("%0t mismatch %s expected %0d actual %0d", $time, name, exp_v, act_v);
      end
   endtask

   // result side: check each item, random stalls and a long hold-off on request
   always @(posedge clock) begin
      clip_res_type e;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            results_seen++;
            if (rsp_item.rej) rejects_seen++;
            if (clipped_q.size() == 0) begin
               errors++;
               $display("%0t unexpected result item, nothing expected", $time);
            end else begin
               e = clipped_q.pop_front();
               check_field("rejected", e.rej, rsp_item.rej);
               check_field("out_pos_left", e.pl, rsp_item.pl);
               check_field("out_pos_top", e.pt, rsp_item.pt);
               check_field("out_pos_right", e.pr, rsp_item.pr);
               check_field("out_pos_bottom", e.pb, rsp_item.pb);
               check_field("out_tex_left", e.tl, rsp_item.tl);
               check_field("out_tex_top", e.tt, rsp_item.tt);
               check_field("out_tex_right", e.tr, rsp_item.tr);
               check_field("out_tex_bottom", e.tb, rsp_item.tb);
            end
         end
         if (hold_request) begin
            hold_request = 1'b0;
            hold_left = 400;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else if (no_idle) begin
            rsp_ready <= 1'b1;
         end else begin
            rsp_ready <= ($urandom_range(99) >= 33);
         end
      end
   end

   // offer one item, hold it until taken, then maybe idle
   task automatic send_rect(rect_type r, bit typed, clip_res_type typed_res);
      req_valid <= 1'b1;
      req_item <= r;
      do @(posedge clock); while (!req_ready);
      clipped_q.push_back(typed ? typed_res : clip_rect(r));
      items_sent++;
      if (!no_idle && $urandom_range(99) < 20) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      @(posedge clock);
      while (clipped_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // clip window write, plus one write to an unused index
   task automatic set_clip(int cl, int ct, int cr, int cb);
      int v[4];
      v = '{cl, ct, cr, cb};
      for (int i = 0; i < 4; i++) begin
         csr_write <= 1'b1;
         csr_index <= CSR_INDEX_BITS'(i);
         csr_data <= v[i][PB-1:0];
         @(posedge clock);
         clip_edge[i] = v[i][PB-1:0];
      end
      csr_index <= CSR_INDEX_BITS'(4 + $urandom_range(3));
      csr_data <= PB'($urandom);
      @(posedge clock);
      csr_write <= 1'b0;
      @(posedge clock);
   endtask

   function automatic logic signed [PB-1:0] rand_pos();
      if ($urandom_range(99) < 30) return PB'($urandom);
      return PB'(int'($urandom_range(0, 10000)) - 5000);
   endfunction

   function automatic rect_type rand_rect();
      rect_type r;
      logic signed [PB-1:0] a, b;
      r.tl = TB'($urandom); r.tt = TB'($urandom);
      r.tr = TB'($urandom); r.tb = TB'($urandom);
      a = rand_pos(); b = rand_pos();
      if ($urandom_range(99) < 85 && a > b) begin
         r.pl = b; r.pr = a;
      end else begin
         r.pl = a; r.pr = b;
      end
      a = rand_pos(); b = rand_pos();
      if ($urandom_range(99) < 85 && a > b) begin
         r.pt = b; r.pb = a;
      end else begin
         r.pt = a; r.pb = b;
      end
      return r;
   endfunction

   function automatic clip_res_type pass_res(rect_type r);
      return {1'b0, r};
   endfunction

   localparam clip_res_type REJ = {1'b1, 128'd0};

   initial begin
      table_row_type rows_full[$];
      table_row_type rows_win[$];
      rect_type r;
      clip_res_type none;
      int cfg[6][4];
      none = '0;
      clip_edge = '{-32768, -32768, 32767, 32767};

      // rows under the reset clip window
      r = '{0, 0, 160, 160, 0, 0, 4096, 4096};
      rows_full.push_back('{r, 1, pass_res(r)});
      r = '{-32768, -32768, 32767, 32767, -32768, -32768, 32767, 32767};
      rows_full.push_back('{r, 1, pass_res(r)});
      r = '{32767, 32767, -32768, -32768, 32767, 32767, -32768, -32768};
      rows_full.push_back('{r, 1, pass_res(r)});
      r = '{100, 100, -100, -100, 5, -5, 700, -700};
      rows_full.push_back('{r, 1, pass_res(r)});
      r = '{7, 7, 7, 7, 1234, -1234, 99, -99};
      rows_full.push_back('{r, 1, pass_res(r)});

      // rows under a window of +-100.0
      rows_win.push_back('{'{-3000, 0, -1700, 10, 1, 2, 3, 4}, 1, REJ});
      rows_win.push_back('{'{1700, 0, 3000, 10, 1, 2, 3, 4}, 1, REJ});
      rows_win.push_back('{'{0, -3000, 10, -1700, 1, 2, 3, 4}, 1, REJ});
      rows_win.push_back('{'{0, 1700, 10, 3000, 1, 2, 3, 4}, 1, REJ});
      rows_win.push_back('{'{-32768, -32768, -32768, -32768, 0, 0, 0, 0}, 1, REJ});
      rows_win.push_back('{'{32767, 32767, 32767, 32767, -1, -1, -1, -1}, 1, REJ});
      rows_win.push_back('{'{-2000, -2000, -1600, -1600, 0, 0, 4096, 4096}, 0, none});
      rows_win.push_back('{'{1600, 1600, 2000, 2000, 0, 0, 4096, 4096}, 0, none});
      rows_win.push_back('{'{-3200, -3200, 3200, 3200, 0, 0, 4096, 4096}, 0, none});
      rows_win.push_back('{'{-32768, -32768, 32767, 32767, -32768, 32767, 32767, -32768},
                          0, none});
      rows_win.push_back('{'{-32768, -32768, 32767, 32767, 32767, -32768, -32768, 32767},
                          0, none});
      rows_win.push_back('{'{0, -3000, 0, 3000, 100, -200, 300, 400}, 0, none});
      rows_win.push_back('{'{-1601, 0, 1601, 0, 32767, 5, -32768, 6}, 0, none});
      rows_win.push_back('{'{500, 500, -500, -500, 10, 20, 30, 40}, 0, none});
      rows_win.push_back('{'{-5000, -1000, 900, 5000, -100, 200, 8000, -9000}, 0, none});

      cfg[0] = '{-32768, -32768, 32767, 32767};
      cfg[1] = '{-3000, -2000, 3000, 2000};
      cfg[2] = '{0, 0, 0, 0};
      cfg[3] = '{32767, 32767, -32768, -32768};
      cfg[4] = '{-32768, -100, 32767, 100};
      cfg[5] = '{-500, -4000, 4500, 800};

      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed table, reset window first
      foreach (rows_full[i]) send_rect(rows_full[i].item, rows_full[i].typed, rows_full[i].res);
      wait_drained();
      set_clip(-1600, -1600, 1600, 1600);
      foreach (rows_win[i]) send_rect(rows_win[i].item, rows_win[i].typed, rows_win[i].res);
      wait_drained();

      // random phases over several windows
      for (int p = 0; p < 8; p++) begin
         if (p < 6) set_clip(cfg[p][0], cfg[p][1], cfg[p][2], cfg[p][3]);
         else set_clip(rand_pos(), rand_pos(), rand_pos(), rand_pos());
         no_idle = (p == 2 || p == 5);
         if (p == 3) hold_request = 1'b1;
         repeat (170) send_rect(rand_rect(), 0, none);
         no_idle = 1'b0;
         wait_drained();
      end

      $display("covered %0d items, %0d results, %0d rejected, over ten clip windows",
               items_sent, results_seen, rejects_seen);
      if (errors == 0 && clipped_q.size() == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

   initial begin
      #(12 * 500000);
      $display("FAILED: results differ");
      $finish;
   end
endmodule
